[rtl/core/nbtl_pkg.sv]
// Package for the NLDM bilinear table lookup: codes, state types, fixed widths.
// Depends on nothing; nbtl_muldiv and the top level refer to it by scoped names.
`default_nettype none
package nbtl_pkg;

  typedef enum logic [1:0] {
    ACT_SLEW_BP  = 2'd0,
    ACT_LOAD_BP  = 2'd1,
    ACT_TABLE    = 2'd2,
    ACT_LOOKUP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LOAD  = 2'd1,
    ST_DEGEN = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_SLEW_USED = 1'b0,
    REG_LOAD_USED = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_ADDR,
    S_SCAN_DATA,
    S_DELTA,
    S_TAB_ADDR,
    S_TAB_DATA,
    S_LERP_START,
    S_LERP_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic done;
    logic sat;
  } md_status_t;

  localparam int ENTRY_W = 32;
  localparam int QUERY_W = 31;
  localparam int VAL_W   = 42;   // clamped lerp value, +-2^40
  localparam int DIFF_W  = 43;
  localparam int T_W     = 34;
  localparam int DEN_W   = 33;
  localparam int PROD_W  = 76;
  localparam int REG_W   = 4;

  localparam logic [40:0] CLAMP_MAG = 41'h100_0000_0000;

endpackage
`default_nettype wire

[rtl/core/nbtl_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the breakpoint axes and the table store; no package dependency.
`default_nettype none
module nbtl_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/nbtl_muldiv.sv]
// Sequential a*b/d unit: split multiply of the operand halves, then 76-step restoring divide.
// Quotient truncated toward zero and clamped at 2^40. Uses nbtl_pkg.
`default_nettype none
module nbtl_muldiv (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [nbtl_pkg::DIFF_W-1:0] a,
  input  wire logic signed [nbtl_pkg::T_W-1:0]    b,
  input  wire logic signed [nbtl_pkg::DEN_W-1:0]  d,
  output logic signed      [nbtl_pkg::VAL_W-1:0]  q,
  output nbtl_pkg::md_status_t                    stat
);

  localparam int PW = nbtl_pkg::PROD_W;
  localparam int VW = nbtl_pkg::VAL_W;

  nbtl_pkg::md_state_t state, state_next;

  logic [41:0]    ma;
  logic [33:0]    mb;
  logic [32:0]    md;
  logic           neg;
  logic [6:0]     cnt;
  logic [37:0]    pp;
  logic [6:0]     psh;
  logic [PW-1:0]  acc;
  logic [33:0]    rem;
  logic [VW-1:0]  qr;

  logic [nbtl_pkg::DIFF_W-1:0] a_abs;
  logic [nbtl_pkg::T_W-1:0]    b_abs;
  logic [nbtl_pkg::DEN_W-1:0]  d_abs;
  logic [20:0]    a_half;
  logic [16:0]    b_half;
  logic [34:0]    rem_s;
  logic           ge;
  logic [VW-1:0]  q_sh;
  logic [VW-1:0]  q_mag;
  logic           over;

  always_comb begin
    a_abs  = a[nbtl_pkg::DIFF_W-1] ? -a : a;
    b_abs  = b[nbtl_pkg::T_W-1] ? -b : b;
    d_abs  = d[nbtl_pkg::DEN_W-1] ? -d : d;
    a_half = cnt[1] ? ma[41:21] : ma[20:0];
    b_half = cnt[0] ? mb[33:17] : mb[16:0];
    rem_s  = {rem, acc[PW-1]};
    ge     = rem_s >= {2'b00, md};
    q_sh   = {qr[VW-2:0], ge};
    if (q_sh > VW'(nbtl_pkg::CLAMP_MAG)) begin
      q_sh = VW'(nbtl_pkg::CLAMP_MAG) + VW'(1);
    end
    over  = qr > VW'(nbtl_pkg::CLAMP_MAG);
    q_mag = over ? VW'(nbtl_pkg::CLAMP_MAG) : qr;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nbtl_pkg::MD_IDLE: if (start) state_next = nbtl_pkg::MD_MUL;
      nbtl_pkg::MD_MUL:  if (cnt == 7'd4) state_next = nbtl_pkg::MD_DIV;
      nbtl_pkg::MD_DIV:  if (cnt == 7'(PW - 1)) state_next = nbtl_pkg::MD_DONE;
      nbtl_pkg::MD_DONE: state_next = nbtl_pkg::MD_IDLE;
      default:           state_next = nbtl_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    stat.done = state == nbtl_pkg::MD_DONE;
    stat.sat  = over;
    q         = neg ? -$signed(q_mag) : $signed(q_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nbtl_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
    unique case (state)
      nbtl_pkg::MD_IDLE: begin
        ma  <= a_abs[41:0];
        mb  <= b_abs;
        md  <= d_abs;
        neg <= a[nbtl_pkg::DIFF_W-1] ^ b[nbtl_pkg::T_W-1] ^ d[nbtl_pkg::DEN_W-1];
        acc <= '0;
        cnt <= '0;
      end
      nbtl_pkg::MD_MUL: begin
        if (cnt != 7'd4) begin
          pp  <= a_half * b_half;
          psh <= (cnt[1] ? 7'd21 : 7'd0) + (cnt[0] ? 7'd17 : 7'd0);
        end
        if (cnt != 7'd0) begin
          acc <= acc + (PW'(pp) << psh);
        end
        cnt <= (cnt == 7'd4) ? 7'd0 : cnt + 7'd1;
        rem <= '0;
        qr  <= '0;
      end
      nbtl_pkg::MD_DIV: begin
        rem <= ge ? 34'(rem_s - {2'b00, md}) : rem_s[33:0];
        acc <= acc << 1;
        qr  <= q_sh;
        cnt <= cnt + 7'd1;
      end
      nbtl_pkg::MD_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/nldm_bilinear_table_lookup.sv]
// NLDM bilinear table lookup, top level. A load, or a lookup of a bad kind or cell, goes to done.
// A lookup: scan address/data per breakpoint index up to K (the larger hit index), a delta step
// (a zero span ends there), four table reads, three lerps (start, multiply, divide, done), done.
// One item in work at a time; the next transfer is taken the cycle after the result registers.
// rst resets control and sets the axis-length registers to 8; memories are not cleared.
// Uses nbtl_pkg, nbtl_ram, nbtl_muldiv.
`default_nettype none
module nldm_bilinear_table_lookup #(
  parameter int MAX_POINTS = 8,
  parameter int NUM_CELLS  = 64,
  parameter int NUM_KINDS  = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // kind[2:0] cell[8:3] row[11:9] col[14:12] load_data[46:15] slew[77:47] load[108:78]
  input  wire logic [111:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_value[30:0]
  output logic [31:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [3:0]   cfg_data
);

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int DEPTH = NUM_CELLS * NUM_KINDS * MAX_POINTS * MAX_POINTS;
  localparam int TW    = $clog2(DEPTH);
  localparam int BW    = $clog2(NUM_CELLS * NUM_KINDS + 1);
  localparam int VW    = nbtl_pkg::VAL_W;

  nbtl_pkg::action_t action;
  logic [2:0]        table_kind;
  logic [5:0]        cell_index;
  logic [2:0]        row_position;
  logic [2:0]        column_position;
  logic [31:0]       load_data;
  logic [30:0]       query_slew;
  logic [30:0]       query_load;

  assign action          = nbtl_pkg::action_t'(s_axis_tuser);
  assign table_kind      = s_axis_tdata[2:0];
  assign cell_index      = s_axis_tdata[8:3];
  assign row_position    = s_axis_tdata[11:9];
  assign column_position = s_axis_tdata[14:12];
  assign load_data       = s_axis_tdata[46:15];
  assign query_slew      = s_axis_tdata[77:47];
  assign query_load      = s_axis_tdata[108:78];

  nbtl_pkg::state_t state, state_next;

  logic [3:0]   slew_points_used, load_points_used;
  logic [PW-1:0] k, x2, y2, j_row, j_col;
  logic         s_done, l_done;
  logic signed [31:0] s_lo, s_hi, l_lo, l_hi;
  logic [BW-1:0] base;
  logic [30:0]  qs, ql;
  logic signed [32:0] dl, ds;
  logic signed [33:0] tl, ts;
  logic [31:0]  e [4];
  logic [1:0]   j, phase;
  logic signed [VW-1:0] a_val, b_val;
  logic         sat;
  logic [30:0]  res_val;
  nbtl_pkg::status_t res_st;

  logic         xfer;
  logic         ok_tab;
  logic [PW-1:0] s_last, l_last;
  logic [NW-1:0] ns, nl;
  logic         s_hit, l_hit;
  logic signed [32:0] dl_c, ds_c;
  logic signed [VW-1:0] p0, p1;
  logic signed [nbtl_pkg::DIFF_W-1:0] diff, sum, clamped;
  logic signed [33:0] t_sel;
  logic signed [32:0] den_sel;
  logic         out_free;

  logic         sbp_we, lbp_we, tab_we;
  logic [PW-1:0] row_idx, col_idx;
  logic [TW-1:0] tab_waddr, tab_raddr;
  logic [31:0]  sbp_rd, lbp_rd, tab_rd;

  logic                      md_start;
  logic signed [VW-1:0]      md_q;
  nbtl_pkg::md_status_t      md_stat;

  assign xfer     = s_axis_tvalid && s_axis_tready;
  assign ok_tab   = 32'(table_kind) < NUM_KINDS && 32'(cell_index) < NUM_CELLS;
  assign row_idx  = PW'(32'(row_position));
  assign col_idx  = PW'(32'(column_position));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    if (slew_points_used < 4'd2) ns = NW'(2);
    else if (32'(slew_points_used) > MAX_POINTS) ns = NW'(MAX_POINTS);
    else ns = NW'(32'(slew_points_used));
    if (load_points_used < 4'd2) nl = NW'(2);
    else if (32'(load_points_used) > MAX_POINTS) nl = NW'(MAX_POINTS);
    else nl = NW'(32'(load_points_used));
    s_last = PW'(ns - NW'(1));
    l_last = PW'(nl - NW'(1));
    s_hit  = !s_done && k != '0 &&
             ($signed(sbp_rd) >= $signed({1'b0, qs}) || k == s_last);
    l_hit  = !l_done && k != '0 &&
             ($signed(lbp_rd) >= $signed({1'b0, ql}) || k == l_last);
    dl_c   = {l_hi[31], l_hi} - {l_lo[31], l_lo};
    ds_c   = {s_hi[31], s_hi} - {s_lo[31], s_lo};
    j_row  = j[1] ? x2 : x2 - PW'(1);
    j_col  = j[0] ? y2 : y2 - PW'(1);
  end

  always_comb begin
    unique case (phase)
      2'd0: begin
        p0 = VW'($signed(e[0])); p1 = VW'($signed(e[1]));
        t_sel = tl; den_sel = dl;
      end
      2'd1: begin
        p0 = VW'($signed(e[2])); p1 = VW'($signed(e[3]));
        t_sel = tl; den_sel = dl;
      end
      default: begin
        p0 = a_val; p1 = b_val;
        t_sel = ts; den_sel = ds;
      end
    endcase
    diff = {p1[VW-1], p1} - {p0[VW-1], p0};
    sum  = {p0[VW-1], p0} + {md_q[VW-1], md_q};
    if (sum > $signed({2'b00, nbtl_pkg::CLAMP_MAG})) begin
      clamped = $signed({2'b00, nbtl_pkg::CLAMP_MAG});
    end else if (sum < -$signed({2'b00, nbtl_pkg::CLAMP_MAG})) begin
      clamped = -$signed({2'b00, nbtl_pkg::CLAMP_MAG});
    end else begin
      clamped = sum;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nbtl_pkg::S_IDLE: begin
        if (xfer) begin
          if (action == nbtl_pkg::ACT_LOOKUP && ok_tab) state_next = nbtl_pkg::S_SCAN_ADDR;
          else state_next = nbtl_pkg::S_DONE;
        end
      end
      nbtl_pkg::S_SCAN_ADDR: state_next = nbtl_pkg::S_SCAN_DATA;
      nbtl_pkg::S_SCAN_DATA: begin
        if ((s_done || s_hit) && (l_done || l_hit)) state_next = nbtl_pkg::S_DELTA;
        else state_next = nbtl_pkg::S_SCAN_ADDR;
      end
      nbtl_pkg::S_DELTA: begin
        if (dl_c == '0 || ds_c == '0) state_next = nbtl_pkg::S_DONE;
        else state_next = nbtl_pkg::S_TAB_ADDR;
      end
      nbtl_pkg::S_TAB_ADDR: state_next = nbtl_pkg::S_TAB_DATA;
      nbtl_pkg::S_TAB_DATA: begin
        if (j == 2'd3) state_next = nbtl_pkg::S_LERP_START;
        else state_next = nbtl_pkg::S_TAB_ADDR;
      end
      nbtl_pkg::S_LERP_START: state_next = nbtl_pkg::S_LERP_WAIT;
      nbtl_pkg::S_LERP_WAIT: begin
        if (md_stat.done) begin
          if (phase == 2'd2) state_next = nbtl_pkg::S_DONE;
          else state_next = nbtl_pkg::S_LERP_START;
        end
      end
      nbtl_pkg::S_DONE: if (out_free) state_next = nbtl_pkg::S_IDLE;
      default: state_next = nbtl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == nbtl_pkg::S_IDLE;
    md_start      = state == nbtl_pkg::S_LERP_START;
    sbp_we        = xfer && action == nbtl_pkg::ACT_SLEW_BP && 32'(row_position) < MAX_POINTS;
    lbp_we        = xfer && action == nbtl_pkg::ACT_LOAD_BP &&
                    32'(column_position) < MAX_POINTS;
    tab_we        = xfer && action == nbtl_pkg::ACT_TABLE && ok_tab &&
                    32'(row_position) < MAX_POINTS && 32'(column_position) < MAX_POINTS;
    tab_waddr     = TW'((32'(cell_index) * NUM_KINDS + 32'(table_kind)) *
                        (MAX_POINTS * MAX_POINTS) + 32'(row_idx) * MAX_POINTS + 32'(col_idx));
    tab_raddr     = TW'(32'(base) * (MAX_POINTS * MAX_POINTS) +
                        32'(j_row) * MAX_POINTS + 32'(j_col));
  end

  nbtl_ram #(.DEPTH(MAX_POINTS), .WIDTH(32)) u_slew_bp (
    .clk(clk), .we(sbp_we), .waddr(row_idx), .wdata(load_data), .raddr(k), .rdata(sbp_rd)
  );

  nbtl_ram #(.DEPTH(MAX_POINTS), .WIDTH(32)) u_load_bp (
    .clk(clk), .we(lbp_we), .waddr(col_idx), .wdata(load_data), .raddr(k), .rdata(lbp_rd)
  );

  nbtl_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(load_data),
    .raddr(tab_raddr), .rdata(tab_rd)
  );

  nbtl_muldiv u_muldiv (
    .clk(clk), .rst(rst), .start(md_start), .a(diff), .b(t_sel), .d(den_sel),
    .q(md_q), .stat(md_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= nbtl_pkg::S_IDLE;
      slew_points_used <= 4'd8;
      load_points_used <= 4'd8;
      m_axis_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (nbtl_pkg::cfg_reg_t'(cfg_index))
          nbtl_pkg::REG_SLEW_USED: slew_points_used <= cfg_data;
          nbtl_pkg::REG_LOAD_USED: load_points_used <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == nbtl_pkg::S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end

    if (state == nbtl_pkg::S_DONE && out_free) begin
      m_axis_tdata <= {1'b0, res_val};
      m_axis_tuser <= res_st;
    end

    unique case (state)
      nbtl_pkg::S_IDLE: begin
        k      <= '0;
        s_done <= 1'b0;
        l_done <= 1'b0;
        j      <= '0;
        phase  <= '0;
        sat    <= 1'b0;
        base   <= BW'(32'(cell_index) * NUM_KINDS + 32'(table_kind));
        qs     <= query_slew;
        ql     <= query_load;
        res_val <= '0;
        res_st  <= (action == nbtl_pkg::ACT_LOOKUP) ? nbtl_pkg::ST_DEGEN : nbtl_pkg::ST_LOAD;
      end
      nbtl_pkg::S_SCAN_ADDR: begin
      end
      nbtl_pkg::S_SCAN_DATA: begin
        if (k == '0) begin
          s_lo <= sbp_rd;
          l_lo <= lbp_rd;
        end else begin
          if (s_hit) begin
            s_hi <= sbp_rd; x2 <= k; s_done <= 1'b1;
          end else if (!s_done) begin
            s_lo <= sbp_rd;
          end
          if (l_hit) begin
            l_hi <= lbp_rd; y2 <= k; l_done <= 1'b1;
          end else if (!l_done) begin
            l_lo <= lbp_rd;
          end
        end
        k <= k + PW'(1);
      end
      nbtl_pkg::S_DELTA: begin
        dl <= dl_c;
        ds <= ds_c;
        tl <= {3'b000, ql} - {{2{l_lo[31]}}, l_lo};
        ts <= {3'b000, qs} - {{2{s_lo[31]}}, s_lo};
      end
      nbtl_pkg::S_TAB_ADDR: begin
      end
      nbtl_pkg::S_TAB_DATA: begin
        e[j] <= tab_rd;
        j    <= j + 2'd1;
      end
      nbtl_pkg::S_LERP_START: begin
      end
      nbtl_pkg::S_LERP_WAIT: begin
        if (md_stat.done) begin
          phase <= phase + 2'd1;
          if (md_stat.sat || clamped != sum) sat <= 1'b1;
          unique case (phase)
            2'd0: a_val <= VW'(clamped);
            2'd1: b_val <= VW'(clamped);
            default: begin
              if (clamped[nbtl_pkg::DIFF_W-1]) begin
                res_val <= '0;
                res_st  <= (md_stat.sat || clamped != sum || sat) ?
                           nbtl_pkg::ST_SAT : nbtl_pkg::ST_OK;
              end else if (clamped > $signed(43'h7FFF_FFFF)) begin
                res_val <= 31'h7FFF_FFFF;
                res_st  <= nbtl_pkg::ST_SAT;
              end else begin
                res_val <= clamped[30:0];
                res_st  <= (md_stat.sat || clamped != sum || sat) ?
                           nbtl_pkg::ST_SAT : nbtl_pkg::ST_OK;
              end
            end
          endcase
        end
      end
      nbtl_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (sbp_we || lbp_we || tab_we) |-> state == nbtl_pkg::S_IDLE)
    else $error("memory write outside idle");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    xfer |=> !s_axis_tready)
    else $error("second item taken while busy");

  a_md_done_wait: assert property (@(posedge clk) disable iff (rst)
    md_stat.done |-> state == nbtl_pkg::S_LERP_WAIT)
    else $error("divider finished outside lerp wait");

  a_zero_on_flag: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == nbtl_pkg::ST_DEGEN ||
                       m_axis_tuser == nbtl_pkg::ST_LOAD)) |-> m_axis_tdata == '0)
    else $error("nonzero value with load or degenerate status");

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for nldm_bilinear_table_lookup: directed table, then random load/lookup traffic.
// Expected results come from an in-bench Q16.16 bilinear interpolator; depends on nbtl_pkg.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 8;
  localparam int NCELLS = 64;
  localparam int NKINDS = 6;
  localparam int DEPTH = NCELLS * NKINDS * NPTS * NPTS;
  localparam int IDLE_LIMIT = 5000;
  localparam longint LIM40 = 64'sd1 << 40;

  typedef struct packed {
    nbtl_pkg::action_t  act;
    logic [2:0]         kind;
    logic [5:0]         cell_no;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] data;
    logic [30:0]        qs;
    logic [30:0]        ql;
  } item_t;

  typedef struct packed {
    logic [30:0]        value;
    nbtl_pkg::status_t  status;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we = 1'b0;
  nbtl_pkg::cfg_reg_t cfg_index = nbtl_pkg::REG_SLEW_USED;
  logic [3:0]   cfg_data = '0;

  always #10 clk = ~clk;

  nldm_bilinear_table_lookup u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // interpolator state
  logic signed [31:0] tbl_val [0:DEPTH-1];
  bit                 tbl_set [0:DEPTH-1];
  logic signed [31:0] slew_bp [0:NPTS-1];
  logic signed [31:0] load_bp [0:NPTS-1];
  logic [3:0]         slew_used = 4'd8;
  logic [3:0]         load_used = 4'd8;

  result_t expected_q[$];
  int      errors = 0;
  int      sent = 0;
  bit      quiet = 1'b0;
  bit      long_hold_req = 1'b0;

  function automatic int tbl_addr(int cell_no, int kind, int r, int c);
    return ((cell_no * NKINDS + kind) * NPTS + r) * NPTS + c;
  endfunction

  function automatic int axis_n(logic [3:0] v);
    if (v < 2) return 2;
    if (v > NPTS) return NPTS;
    return v;
  endfunction

  function automatic int seg_hi(bit slew_axis, int n, longint q);
    int k;
    for (k = 1; k < n - 1; k++)
      if ((slew_axis ? longint'(slew_bp[k]) : longint'(load_bp[k])) >= q) break;
    return k;
  endfunction

  // true when the lookup will read the four table corners
  function automatic bit lookup_corners(item_t it, output int x1, output int x2,
                                        output int y1, output int y2);
    x2 = seg_hi(1'b1, axis_n(slew_used), longint'(it.qs));
    x1 = x2 - 1;
    y2 = seg_hi(1'b0, axis_n(load_used), longint'(it.ql));
    y1 = y2 - 1;
    if (it.kind >= NKINDS) return 1'b0;
    if (slew_bp[x2] == slew_bp[x1] || load_bp[y2] == load_bp[y1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint lerp_q(longint p0, longint p1, longint t, longint den,
                                    inout bit sat);
    longint diff, v;
    logic [127:0] ma, mb, md, q;
    bit neg;
    diff = p1 - p0;
    neg = ((diff < 0) != (t < 0)) != (den < 0);
    ma = diff < 0 ? -diff : diff;
    mb = t < 0 ? -t : t;
    md = den < 0 ? -den : den;
    q = (ma * mb) / md;
    if (q > LIM40) begin
      sat = 1'b1;
      q = LIM40;
    end
    v = p0 + (neg ? -longint'(q) : longint'(q));
    if (v > LIM40) begin
      sat = 1'b1;
      v = LIM40;
    end else if (v < -LIM40) begin
      sat = 1'b1;
      v = -LIM40;
    end
    return v;
  endfunction

  function automatic result_t interpolate(item_t it);
    result_t r;
    int x1, x2, y1, y2;
    longint a, b, v, dl, ds;
    bit sat;
    r.value = '0;
    r.status = nbtl_pkg::ST_LOAD;
    sat = 1'b0;
    case (it.act)
      nbtl_pkg::ACT_SLEW_BP: slew_bp[it.row] = it.data;
      nbtl_pkg::ACT_LOAD_BP: load_bp[it.col] = it.data;
      nbtl_pkg::ACT_TABLE: begin
        if (it.kind < NKINDS) begin
          tbl_val[tbl_addr(it.cell_no, it.kind, it.row, it.col)] = it.data;
          tbl_set[tbl_addr(it.cell_no, it.kind, it.row, it.col)] = 1'b1;
        end
      end
      default: begin
        r.status = nbtl_pkg::ST_DEGEN;
        if (lookup_corners(it, x1, x2, y1, y2)) begin
          dl = longint'(load_bp[y2]) - longint'(load_bp[y1]);
          ds = longint'(slew_bp[x2]) - longint'(slew_bp[x1]);
          a = lerp_q(tbl_val[tbl_addr(it.cell_no, it.kind, x1, y1)],
                     tbl_val[tbl_addr(it.cell_no, it.kind, x1, y2)],
                     longint'(it.ql) - load_bp[y1], dl, sat);
          b = lerp_q(tbl_val[tbl_addr(it.cell_no, it.kind, x2, y1)],
                     tbl_val[tbl_addr(it.cell_no, it.kind, x2, y2)],
                     longint'(it.ql) - load_bp[y1], dl, sat);
          v = lerp_q(a, b, longint'(it.qs) - slew_bp[x1], ds, sat);
          if (v < 0) v = 0;
          if (v > 64'sh7FFF_FFFF) begin
            v = 64'sh7FFF_FFFF;
            sat = 1'b1;
          end
          r.value = v[30:0];
          r.status = sat ? nbtl_pkg::ST_SAT : nbtl_pkg::ST_OK;
        end
      end
    endcase
    return r;
  endfunction

  function automatic item_t mk(nbtl_pkg::action_t act, int kind, int cell_no, int row, int col,
                               logic [31:0] data, logic [30:0] qs, logic [30:0] ql);
    item_t it;
    it.act = act;
    it.kind = 3'(kind);
    it.cell_no = 6'(cell_no);
    it.row = 3'(row);
    it.col = 3'(col);
    it.data = data;
    it.qs = qs;
    it.ql = ql;
    return it;
  endfunction

  task automatic put(item_t it, bit typed = 1'b0, result_t res = '0);
    result_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.act;
    s_axis_tdata <= {3'b0, it.ql, it.qs, it.data, it.col, it.row, it.cell_no, it.kind};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    r = interpolate(it);
    expected_q.push_back(typed ? res : r);
  endtask

  // fills any unwritten corner the lookup would read, then sends the lookup
  task automatic send(item_t it, bit typed = 1'b0, result_t res = '0);
    int x[4];
    if (it.act == nbtl_pkg::ACT_LOOKUP && lookup_corners(it, x[0], x[1], x[2], x[3])) begin
      for (int i = 0; i < 4; i++) begin
        int r, c;
        r = x[i / 2];
        c = x[2 + i % 2];
        if (!tbl_set[tbl_addr(it.cell_no, it.kind, r, c)])
          put(mk(nbtl_pkg::ACT_TABLE, it.kind, it.cell_no, r, c,
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h00FF_FFFF),
                 0, 0));
      end
    end
    put(it, typed, res);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_axes(logic [3:0] ns, logic [3:0] nl);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= nbtl_pkg::REG_SLEW_USED;
    cfg_data <= ns;
    @(posedge clk);
    cfg_index <= nbtl_pkg::REG_LOAD_USED;
    cfg_data <= nl;
    @(posedge clk);
    cfg_we <= 1'b0;
    slew_used = ns;
    load_used = nl;
    @(posedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    int p, step;
    longint top;
    it = mk(nbtl_pkg::ACT_LOOKUP, $urandom_range(0, 5), $urandom_range(0, 7),
            $urandom_range(0, 7), $urandom_range(0, 7), $urandom, 0, 0);
    if ($urandom_range(0, 9) == 0) it.kind = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) it.cell_no = 6'($urandom_range(0, 63));
    p = $urandom_range(0, 99);
    if (p < 8) begin
      it.act = $urandom_range(0, 1) ? nbtl_pkg::ACT_SLEW_BP : nbtl_pkg::ACT_LOAD_BP;
      step = it.act == nbtl_pkg::ACT_SLEW_BP ? 32'h2_0000 : 32'h3_0000;
      p = it.act == nbtl_pkg::ACT_SLEW_BP ? it.row : it.col;
      case ($urandom_range(0, 5))
        0: it.data = $urandom;
        1: it.data = p > 0 ? (it.act == nbtl_pkg::ACT_SLEW_BP ? slew_bp[p - 1] :
                                                                 load_bp[p - 1]) : 0;
        default: it.data = p * step + $urandom_range(0, step / 2);
      endcase
    end else if (p < 30) begin
      it.act = nbtl_pkg::ACT_TABLE;
      if ($urandom_range(0, 3) != 0)
        it.data = $signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
    end else begin
      top = 64'h10_0000 + 8 * 64'h3_0000;
      it.qs = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, top));
      it.ql = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, top));
    end
    return it;
  endfunction

  // result checker and sink-side stalls
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: value=%h status=%0d",
                                     m_axis_tdata[30:0], m_axis_tuser);
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (m_axis_tdata[30:0] !== e.value || m_axis_tuser !== e.status ||
              m_axis_tdata[31] !== 1'b0) begin
            errors++;
            if (errors <= 10) $display("mismatch: exp value=%h status=%0d got value=%h status=%0d",
                                       e.value, e.status, m_axis_tdata[30:0], m_axis_tuser);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 399;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t dir[$];
    result_t ld, dg;
    int goal;
    ld = '{value: '0, status: nbtl_pkg::ST_LOAD};
    dg = '{value: '0, status: nbtl_pkg::ST_DEGEN};
    for (int i = 0; i < DEPTH; i++) begin
      tbl_val[i] = '0;
      tbl_set[i] = 1'b0;
    end
    for (int i = 0; i < NPTS; i++) begin
      slew_bp[i] = '0;
      load_bp[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NPTS; i++) begin
      send(mk(nbtl_pkg::ACT_SLEW_BP, 0, 0, i, 0, i * 32'h2_0000 + 32'h1_0000, 0, 0), 1'b1, ld);
      send(mk(nbtl_pkg::ACT_LOAD_BP, 0, 0, 0, i, i * 32'h3_0000, 0, 0), 1'b1, ld);
    end

    dir.push_back('{mk(nbtl_pkg::ACT_TABLE, 7, 3, 1, 1, 32'h1234, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_TABLE, 5, 63, 7, 7, 32'h7FFF_FFFF, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_TABLE, 5, 63, 7, 6, 32'h8000_0000, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_TABLE, 5, 63, 6, 7, 32'h8000_0000, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_TABLE, 5, 63, 6, 6, 32'h7FFF_FFFF, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 6, 0, 0, 0, 0, 31'h1_0000, 31'h1_0000), 1'b1, dg});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 7, 63, 0, 0, 0, 0, 0), 1'b1, dg});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 5, 63, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
                    1'b0, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 5, 63, 0, 0, 0, 31'h11_0000, 31'h16_0000), 1'b0, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1'b0, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 1, 1, 0, 0, 0, 31'h4_8000, 31'h7_4000), 1'b0, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 2, 2, 0, 0, 0, 31'h1_0000, 31'h0), 1'b0, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_SLEW_BP, 0, 0, 1, 0, 32'h1_0000, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 3, 4, 0, 0, 0, 31'h0, 31'h5_0000), 1'b1, dg});
    dir.push_back('{mk(nbtl_pkg::ACT_SLEW_BP, 0, 0, 1, 0, 32'h3_0000, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOAD_BP, 0, 0, 0, 1, 32'h0, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 4, 5, 0, 0, 0, 31'h6_0000, 31'h0), 1'b1, dg});
    dir.push_back('{mk(nbtl_pkg::ACT_LOAD_BP, 0, 0, 0, 1, 32'h3_0000, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_TABLE, 1, 9, 0, 0, 32'hFFFF_FFFF, 0, 0), 1'b1, ld});
    dir.push_back('{mk(nbtl_pkg::ACT_LOOKUP, 1, 9, 0, 0, 0, 31'h0, 31'h0), 1'b0, ld});
    foreach (dir[i]) send(dir[i].it, dir[i].typed, dir[i].res);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_axes(4'd2, 4'd2);
        1: set_axes(4'd0, 4'd15);
        2: set_axes(4'd5, 4'd3);
        3: set_axes(4'($urandom), 4'($urandom));
        default: set_axes(4'd8, 4'd8);
      endcase
      goal = sent + 180;
      for (int n = 0; sent < goal; n++) begin
        if (ph == 1 && n == 20) long_hold_req = 1'b1;
        if (ph == 4 && sent >= goal - 90) quiet = 1'b1;
        send(rand_item());
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
